// ----- rtl/ecdt_pkg.sv -----
// ecdt_pkg: constants, result types and shared helpers of the epoch-to-civil converter
// used by every module under epoch_ms_to_civil_datetime; depends on nothing
package ecdt_pkg;

  // input and offset widths
  localparam int MS_W = 49;
  localparam int U_W  = 50;

  // offset of 3257813 whole days makes every timestamp non-negative
  localparam logic [U_W-1:0] MS_OFFSET = 50'd281475043200000;

  // day split: ms per day is 1024 * 84375
  localparam int DS_XW     = 40;
  localparam int DS_QW     = 23;
  localparam int DS_STEP   = 4;
  localparam int DS_STAGES = 6;
  localparam int DAY_DIV   = 84375;

  // calendar constants
  localparam logic [22:0] ZZ_OFFSET = 23'd91401;   // 719468 - 3257813 + 18 eras
  localparam int ERA_DAYS   = 146097;
  localparam int ERA_LAST   = 146096;
  localparam int LEAP4_DAYS = 1460;
  localparam int CENT_DAYS  = 36524;
  localparam int YEAR_DAYS  = 365;
  localparam int MP_DIV     = 153;
  localparam int YEAR_BIAS  = 7200;                // 18 eras of 400 years
  localparam int YEAR_MAX   = 9999;

  // time of day
  localparam int MS_HOUR = 3600000;
  localparam int MS_MIN  = 60000;
  localparam int MS_SEC  = 1000;

  // pipeline depths
  localparam int CIVIL_STAGES = 10;
  localparam int TOD_STAGES   = 6;
  localparam int TOD_DELAY    = CIVIL_STAGES - TOD_STAGES;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        status;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] msec;
  } tod_t;

  typedef struct packed {
    logic [DS_XW-1:0] rem;
    logic [DS_QW-1:0] quo;
  } divst_t;

  // restoring division steps: quotient bits top down to top-cnt+1
  function automatic divst_t div_steps(logic [DS_XW-1:0] rem, logic [DS_QW-1:0] quo,
                                       logic [DS_XW-1:0] dvs, int top, int cnt);
    divst_t           r;
    int               b;
    logic [DS_XW-1:0] sh;
    r.rem = rem;
    r.quo = quo;
    for (int j = 0; j < 8; j++) begin
      b = top - j;
      if (j < cnt && b >= 0) begin
        sh = dvs << b;
        if (r.rem >= sh) begin
          r.rem = r.rem - sh;
          r.quo = r.quo | (DS_QW'(1) << b);
        end
      end
    end
    return r;
  endfunction

  // first day of each march-based month, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/ecdt_day_split.sv -----
// ecdt_day_split: pipelined restoring divider that splits offset milliseconds
// into a day count and a millisecond-of-day; depends on ecdt_pkg
module ecdt_day_split (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  logic [ecdt_pkg::U_W-1:0] u_i,
  output logic                     valid_o,
  output logic [22:0]              days_o,
  output logic [26:0]              rem_o
);

  logic [ecdt_pkg::DS_XW-1:0] x_r   [ecdt_pkg::DS_STAGES];
  logic [ecdt_pkg::DS_QW-1:0] q_r   [ecdt_pkg::DS_STAGES];
  logic [9:0]                 lo_r  [ecdt_pkg::DS_STAGES];
  logic                       v_r   [ecdt_pkg::DS_STAGES];
  logic [ecdt_pkg::DS_XW-1:0] x_in  [ecdt_pkg::DS_STAGES];
  logic [ecdt_pkg::DS_QW-1:0] q_in  [ecdt_pkg::DS_STAGES];
  logic [9:0]                 lo_in [ecdt_pkg::DS_STAGES];
  logic                       v_in  [ecdt_pkg::DS_STAGES];
  ecdt_pkg::divst_t           st_nxt [ecdt_pkg::DS_STAGES];

  // stage inputs: the first takes the offset timestamp over 1024
  always_comb begin
    x_in[0]  = u_i[ecdt_pkg::U_W-1:10];
    q_in[0]  = '0;
    lo_in[0] = u_i[9:0];
    v_in[0]  = valid_i;
    for (int s = 1; s < ecdt_pkg::DS_STAGES; s++) begin
      x_in[s]  = x_r[s-1];
      q_in[s]  = q_r[s-1];
      lo_in[s] = lo_r[s-1];
      v_in[s]  = v_r[s-1];
    end
  end

  // four quotient bits per stage, three in the last
  always_comb begin
    for (int s = 0; s < ecdt_pkg::DS_STAGES; s++) begin
      st_nxt[s] = ecdt_pkg::div_steps(x_in[s], q_in[s],
                                      ecdt_pkg::DS_XW'(ecdt_pkg::DAY_DIV),
                                      ecdt_pkg::DS_QW - 1 - s * ecdt_pkg::DS_STEP,
                                      ecdt_pkg::DS_STEP);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int s = 0; s < ecdt_pkg::DS_STAGES; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in[s];
      end
      x_r[s]  <= st_nxt[s].rem;
      q_r[s]  <= st_nxt[s].quo;
      lo_r[s] <= lo_in[s];
    end
  end

  // remainder below 84375 joins the low ten bits
  assign valid_o = v_r[ecdt_pkg::DS_STAGES-1];
  assign days_o  = q_r[ecdt_pkg::DS_STAGES-1];
  assign rem_o   = {x_r[ecdt_pkg::DS_STAGES-1][16:0], lo_r[ecdt_pkg::DS_STAGES-1]};

endmodule

// ----- rtl/ecdt_tod.sv -----
// ecdt_tod: six-stage pipeline that splits the millisecond of day into
// hour, minute, second and millisecond; depends on ecdt_pkg
module ecdt_tod (
  input  logic                 clk,
  input  logic [26:0]          rem_i,
  output ecdt_pkg::tod_t       tod_o
);

  logic [26:0] t1_x_r, t1_x_nxt;
  logic [4:0]  t1_h_r, t1_h_nxt;
  logic [21:0] t2_x_r, t2_x_nxt;
  logic [4:0]  t2_h_r, t2_h_nxt;
  logic [21:0] t3_x_r, t3_x_nxt;
  logic [5:0]  t3_m_r, t3_m_nxt;
  logic [4:0]  t3_h_r;
  logic [15:0] t4_x_r, t4_x_nxt;
  logic [5:0]  t4_m_r, t4_m_nxt;
  logic [4:0]  t4_h_r;
  logic [15:0] t5_x_r, t5_x_nxt;
  logic [5:0]  t5_s_r, t5_s_nxt;
  logic [5:0]  t5_m_r;
  logic [4:0]  t5_h_r;
  ecdt_pkg::tod_t tod_r, tod_nxt;
  ecdt_pkg::divst_t st1, st2, st3, st4, st5, st6;

  // hours, minutes and seconds, three quotient bits a stage at most
  always_comb begin
    st1 = ecdt_pkg::div_steps(40'(rem_i), '0, 40'(ecdt_pkg::MS_HOUR), 4, 3);
    t1_x_nxt = st1.rem[26:0];
    t1_h_nxt = st1.quo[4:0];

    st2 = ecdt_pkg::div_steps(40'(t1_x_r), 23'(t1_h_r), 40'(ecdt_pkg::MS_HOUR), 1, 2);
    t2_x_nxt = st2.rem[21:0];
    t2_h_nxt = st2.quo[4:0];

    st3 = ecdt_pkg::div_steps(40'(t2_x_r), '0, 40'(ecdt_pkg::MS_MIN), 5, 3);
    t3_x_nxt = st3.rem[21:0];
    t3_m_nxt = st3.quo[5:0];

    st4 = ecdt_pkg::div_steps(40'(t3_x_r), 23'(t3_m_r), 40'(ecdt_pkg::MS_MIN), 2, 3);
    t4_x_nxt = st4.rem[15:0];
    t4_m_nxt = st4.quo[5:0];

    st5 = ecdt_pkg::div_steps(40'(t4_x_r), '0, 40'(ecdt_pkg::MS_SEC), 5, 3);
    t5_x_nxt = st5.rem[15:0];
    t5_s_nxt = st5.quo[5:0];

    st6 = ecdt_pkg::div_steps(40'(t5_x_r), 23'(t5_s_r), 40'(ecdt_pkg::MS_SEC), 2, 3);
    tod_nxt.hour   = t5_h_r;
    tod_nxt.minute = t5_m_r;
    tod_nxt.second = st6.quo[5:0];
    tod_nxt.msec   = st6.rem[9:0];
  end

  // payload only, valid travels in the date pipeline
  always_ff @(posedge clk) begin
    t1_x_r <= t1_x_nxt;
    t1_h_r <= t1_h_nxt;
    t2_x_r <= t2_x_nxt;
    t2_h_r <= t2_h_nxt;
    t3_x_r <= t3_x_nxt;
    t3_m_r <= t3_m_nxt;
    t3_h_r <= t2_h_r;
    t4_x_r <= t4_x_nxt;
    t4_m_r <= t4_m_nxt;
    t4_h_r <= t3_h_r;
    t5_x_r <= t5_x_nxt;
    t5_s_r <= t5_s_nxt;
    t5_m_r <= t4_m_r;
    t5_h_r <= t4_h_r;
    tod_r  <= tod_nxt;
  end

  assign tod_o = tod_r;

endmodule

// ----- rtl/ecdt_civil.sv -----
// ecdt_civil: ten-stage pipeline from offset day count to civil year, month,
// day and range status by era and year-of-era; depends on ecdt_pkg
module ecdt_civil (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  logic [22:0]    days_i,
  output logic           valid_o,
  output ecdt_pkg::date_t date_o
);

  logic [22:0] c1_x_r, c1_x_nxt;
  logic [5:0]  c1_q_r, c1_q_nxt;
  logic [17:0] c2_yoe_r, c2_yoe_nxt;
  logic [5:0]  c2_q_r, c2_q_nxt;
  logic [17:0] c3_yoe_r, c3_ax_r, c3_ax_nxt;
  logic [6:0]  c3_aq_r, c3_aq_nxt;
  logic [2:0]  c3_b_r, c3_b_nxt;
  logic        c3_c_r, c3_c_nxt;
  logic [5:0]  c3_q_r;
  logic [17:0] c4_yoe_r;
  logic [6:0]  c4_a_r, c4_a_nxt;
  logic [2:0]  c4_b_r;
  logic        c4_c_r;
  logic [5:0]  c4_q_r;
  logic [17:0] c5_yoe_r, c5_nx_r, c5_nx_nxt, c5_n;
  logic [8:0]  c5_ye_r, c5_ye_nxt;
  logic [5:0]  c5_q_r;
  logic [17:0] c6_yoe_r, c6_nx_r, c6_nx_nxt;
  logic [8:0]  c6_ye_r, c6_ye_nxt;
  logic [5:0]  c6_q_r;
  logic [17:0] c7_yoe_r;
  logic [8:0]  c7_ye_r, c7_ye_nxt;
  logic [5:0]  c7_q_r;
  logic [8:0]  c8_doy_r, c8_doy_nxt;
  logic [8:0]  c8_ye_r;
  logic [5:0]  c8_q_r;
  logic [17:0] c8_sub;
  logic [1:0]  c8_cent;
  logic [8:0]  c9_doy_r;
  logic [3:0]  c9_mp_r, c9_mp_nxt;
  logic [8:0]  c9_ye_r;
  logic [5:0]  c9_q_r;
  logic [10:0] c9_x;
  logic [3:0]  c10_mon;
  logic        c10_adj, c10_bad;
  logic [14:0] c10_yr;
  logic [8:0]  c10_dom;
  ecdt_pkg::date_t date_r, date_nxt;
  logic [9:0]  v_r;
  ecdt_pkg::divst_t st1, st2, st3, st4, st5, st6, st7, st9;

  always_comb begin
    // era: shift to a march-based count and divide by 146097
    st1 = ecdt_pkg::div_steps(40'(days_i + ecdt_pkg::ZZ_OFFSET), '0,
                              40'(ecdt_pkg::ERA_DAYS), 5, 3);
    c1_x_nxt = st1.rem[22:0];
    c1_q_nxt = st1.quo[5:0];

    st2 = ecdt_pkg::div_steps(40'(c1_x_r), 23'(c1_q_r), 40'(ecdt_pkg::ERA_DAYS), 2, 3);
    c2_yoe_nxt = st2.rem[17:0];
    c2_q_nxt   = st2.quo[5:0];

    // year of era: four-year, century and era-end corrections
    st3 = ecdt_pkg::div_steps(40'(c2_yoe_r), '0, 40'(ecdt_pkg::LEAP4_DAYS), 6, 4);
    c3_ax_nxt = st3.rem[17:0];
    c3_aq_nxt = st3.quo[6:0];
    c3_b_nxt  = 3'(c2_yoe_r >= 18'(ecdt_pkg::CENT_DAYS))
              + 3'(c2_yoe_r >= 18'(2 * ecdt_pkg::CENT_DAYS))
              + 3'(c2_yoe_r >= 18'(3 * ecdt_pkg::CENT_DAYS))
              + 3'(c2_yoe_r >= 18'(4 * ecdt_pkg::CENT_DAYS));
    c3_c_nxt  = (c2_yoe_r == 18'(ecdt_pkg::ERA_LAST));

    st4 = ecdt_pkg::div_steps(40'(c3_ax_r), 23'(c3_aq_r), 40'(ecdt_pkg::LEAP4_DAYS), 2, 3);
    c4_a_nxt = st4.quo[6:0];

    // corrected count over 365 days
    c5_n = c4_yoe_r - 18'(c4_a_r) + 18'(c4_b_r) - 18'(c4_c_r);
    st5 = ecdt_pkg::div_steps(40'(c5_n), '0, 40'(ecdt_pkg::YEAR_DAYS), 8, 3);
    c5_nx_nxt = st5.rem[17:0];
    c5_ye_nxt = st5.quo[8:0];

    st6 = ecdt_pkg::div_steps(40'(c5_nx_r), 23'(c5_ye_r), 40'(ecdt_pkg::YEAR_DAYS), 5, 3);
    c6_nx_nxt = st6.rem[17:0];
    c6_ye_nxt = st6.quo[8:0];

    st7 = ecdt_pkg::div_steps(40'(c6_nx_r), 23'(c6_ye_r), 40'(ecdt_pkg::YEAR_DAYS), 2, 3);
    c7_ye_nxt = st7.quo[8:0];

    // day of year
    c8_cent = 2'(c7_ye_r >= 9'd100) + 2'(c7_ye_r >= 9'd200) + 2'(c7_ye_r >= 9'd300);
    c8_sub  = 18'(c7_ye_r) * 18'(ecdt_pkg::YEAR_DAYS) + 18'(c7_ye_r[8:2]) - 18'(c8_cent);
    c8_doy_nxt = 9'(c7_yoe_r - c8_sub);

    // march-based month
    c9_x = 11'(c8_doy_r) * 11'd5 + 11'd2;
    st9 = ecdt_pkg::div_steps(40'(c9_x), '0, 40'(ecdt_pkg::MP_DIV), 3, 4);
    c9_mp_nxt = st9.quo[3:0];

    // civil month, day, year and range check
    c10_adj = (c9_mp_r >= 4'd10);
    c10_mon = c10_adj ? (c9_mp_r - 4'd9) : (c9_mp_r + 4'd3);
    c10_dom = c9_doy_r - ecdt_pkg::month_start(c9_mp_r) + 9'd1;
    c10_yr  = 15'(c9_ye_r) + 15'(c9_q_r) * 15'd400 + 15'(c10_adj);
    c10_bad = (c10_yr < 15'(ecdt_pkg::YEAR_BIAS))
           || (c10_yr > 15'(ecdt_pkg::YEAR_BIAS + ecdt_pkg::YEAR_MAX));
    date_nxt.year   = c10_bad ? '0 : 14'(c10_yr - 15'(ecdt_pkg::YEAR_BIAS));
    date_nxt.month  = c10_bad ? '0 : c10_mon;
    date_nxt.day    = c10_bad ? '0 : c10_dom[4:0];
    date_nxt.status = c10_bad;
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[8:0], valid_i};
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    c1_x_r   <= c1_x_nxt;
    c1_q_r   <= c1_q_nxt;
    c2_yoe_r <= c2_yoe_nxt;
    c2_q_r   <= c2_q_nxt;
    c3_yoe_r <= c2_yoe_r;
    c3_ax_r  <= c3_ax_nxt;
    c3_aq_r  <= c3_aq_nxt;
    c3_b_r   <= c3_b_nxt;
    c3_c_r   <= c3_c_nxt;
    c3_q_r   <= c2_q_r;
    c4_yoe_r <= c3_yoe_r;
    c4_a_r   <= c4_a_nxt;
    c4_b_r   <= c3_b_r;
    c4_c_r   <= c3_c_r;
    c4_q_r   <= c3_q_r;
    c5_yoe_r <= c4_yoe_r;
    c5_nx_r  <= c5_nx_nxt;
    c5_ye_r  <= c5_ye_nxt;
    c5_q_r   <= c4_q_r;
    c6_yoe_r <= c5_yoe_r;
    c6_nx_r  <= c6_nx_nxt;
    c6_ye_r  <= c6_ye_nxt;
    c6_q_r   <= c5_q_r;
    c7_yoe_r <= c6_yoe_r;
    c7_ye_r  <= c7_ye_nxt;
    c7_q_r   <= c6_q_r;
    c8_doy_r <= c8_doy_nxt;
    c8_ye_r  <= c7_ye_r;
    c8_q_r   <= c7_q_r;
    c9_doy_r <= c8_doy_r;
    c9_mp_r  <= c9_mp_nxt;
    c9_ye_r  <= c8_ye_r;
    c9_q_r   <= c8_q_r;
    date_r   <= date_nxt;
  end

  assign valid_o = v_r[9];
  assign date_o  = date_r;

endmodule

// ----- rtl/epoch_ms_to_civil_datetime.sv -----
// epoch_ms_to_civil_datetime: top level of the millisecond timestamp to civil
// date and time converter; depends on ecdt_pkg, ecdt_day_split, ecdt_civil, ecdt_tod
//
//   channel   ports                               transfer
//   input     start, busy, in_ms_since_epoch      start high and busy low at clk
//   result    out_valid, out_year .. out_status   out_valid high for one cycle
//
// one item enters every clock; each result passes the input register, then the 23-bit
// day division (six stages) and the ten-stage calendar pipeline with its era and
// year-of-era divisions
// synchronous active-low reset clears the valid bits only; no clearing pass
// busy is always low and the receiver cannot stall, so nothing ever holds
module epoch_ms_to_civil_datetime (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [48:0] in_ms_since_epoch,
  output logic        out_valid,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [9:0]  out_millisecond,
  output logic        out_status
);

  logic                     in_v_r;
  logic [ecdt_pkg::U_W-1:0] in_u_r, in_u_nxt;
  logic                     ds_valid;
  logic [22:0]              ds_days;
  logic [26:0]              ds_rem;
  logic                     cv_valid;
  ecdt_pkg::date_t          cv_date;
  ecdt_pkg::tod_t           tod;
  ecdt_pkg::tod_t           tod_dly_r [ecdt_pkg::TOD_DELAY];

  assign busy = 1'b0;

  // input stage: offset by whole days so the count is never negative
  assign in_u_nxt = {in_ms_since_epoch[48], in_ms_since_epoch} + ecdt_pkg::MS_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start & ~busy;
    end
    in_u_r <= in_u_nxt;
  end

  // day count and millisecond of day
  ecdt_day_split u_day_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_v_r),
    .u_i     (in_u_r),
    .valid_o (ds_valid),
    .days_o  (ds_days),
    .rem_o   (ds_rem)
  );

  // calendar date
  ecdt_civil u_civil (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (ds_valid),
    .days_i  (ds_days),
    .valid_o (cv_valid),
    .date_o  (cv_date)
  );

  // time of day
  ecdt_tod u_tod (
    .clk   (clk),
    .rem_i (ds_rem),
    .tod_o (tod)
  );

  // align time of day with the longer date pipeline
  always_ff @(posedge clk) begin
    tod_dly_r[0] <= tod;
    for (int i = 1; i < ecdt_pkg::TOD_DELAY; i++) begin
      tod_dly_r[i] <= tod_dly_r[i-1];
    end
  end

  // result ports
  assign out_valid       = cv_valid;
  assign out_year        = cv_date.year;
  assign out_month       = cv_date.month;
  assign out_day         = cv_date.day;
  assign out_status      = cv_date.status;
  assign out_hour        = tod_dly_r[ecdt_pkg::TOD_DELAY-1].hour;
  assign out_minute      = tod_dly_r[ecdt_pkg::TOD_DELAY-1].minute;
  assign out_second      = tod_dly_r[ecdt_pkg::TOD_DELAY-1].second;
  assign out_millisecond = tod_dly_r[ecdt_pkg::TOD_DELAY-1].msec;

endmodule

// ----- tb/ecdt_checker.sv -----
// ecdt_checker: watches the item and result channels of epoch_ms_to_civil_datetime,
// predicts each civil date and time from its timestamp and compares in order
// depends on ecdt_pkg for the date and time-of-day types and the calendar constants
module ecdt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [48:0] in_ms_since_epoch,
  input  logic        out_valid,
  input  logic [13:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day,
  input  logic [4:0]  out_hour,
  input  logic [5:0]  out_minute,
  input  logic [5:0]  out_second,
  input  logic [9:0]  out_millisecond,
  input  logic        out_status,
  output int          fail_count,
  output int          due_count
);

  localparam longint MS_DAY     = 86400000;
  localparam longint EPOCH_DAYS = 719468;   // days from 0000-03-01 to 1970-01-01

  // one predicted result, tagged with the timestamp that caused it
  typedef struct packed {
    logic [48:0]     stamp;
    ecdt_pkg::date_t cal;
    ecdt_pkg::tod_t  tod;
  } civil_t;

  civil_t civil_due_q[$];
  int     fails = 0;

  // quotient rounded toward minus infinity, positive divisor
  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b < 0) q = q - 1;
    return q;
  endfunction

  // timestamp to civil date and time of day
  function automatic civil_t civil_from_ms(logic [48:0] raw);
    civil_t r;
    longint ms, days, rem, z, era, yoe, ye, doy, mp, dom, mon, yr;
    ms   = {{15{raw[48]}}, raw};
    days = floor_quot(ms, MS_DAY);
    rem  = ms - days * MS_DAY;

    // march-based year within a 400-year era
    z   = days + EPOCH_DAYS;
    era = floor_quot(z, ecdt_pkg::ERA_DAYS);
    yoe = z - era * ecdt_pkg::ERA_DAYS;
    ye  = (yoe - yoe / ecdt_pkg::LEAP4_DAYS + yoe / ecdt_pkg::CENT_DAYS
           - yoe / ecdt_pkg::ERA_LAST) / ecdt_pkg::YEAR_DAYS;
    doy = yoe - (ecdt_pkg::YEAR_DAYS * ye + ye / 4 - ye / 100);
    mp  = (5 * doy + 2) / ecdt_pkg::MP_DIV;
    dom = doy - (ecdt_pkg::MP_DIV * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr  = ye + era * 400 + ((mon <= 2) ? 1 : 0);

    r.stamp = raw;
    if (yr < 0 || yr > ecdt_pkg::YEAR_MAX) begin
      r.cal = '0;
      r.cal.status = 1'b1;
    end else begin
      r.cal.year   = yr[13:0];
      r.cal.month  = mon[3:0];
      r.cal.day    = dom[4:0];
      r.cal.status = 1'b0;
    end

    // time of day is valid for every timestamp
    r.tod.hour   = 5'(rem / ecdt_pkg::MS_HOUR);
    rem          = rem % ecdt_pkg::MS_HOUR;
    r.tod.minute = 6'(rem / ecdt_pkg::MS_MIN);
    rem          = rem % ecdt_pkg::MS_MIN;
    r.tod.second = 6'(rem / ecdt_pkg::MS_SEC);
    r.tod.msec   = 10'(rem % ecdt_pkg::MS_SEC);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ecdt_checker mismatch: %s", $time, msg);
    fails = fails + 1;
  endtask

  task automatic check_field(string name, logic [13:0] want, logic [13:0] got,
                             logic [48:0] stamp);
    if (got !== want)
      report_mismatch($sformatf("%s expected %0d got %0d for stamp %0d", name, want, got,
                                $signed(stamp)));
  endtask

  // record accepted items, compare each result with the oldest prediction
  always @(posedge clk) begin : watch
    civil_t want;
    if (rst_n) begin
      if (start && !busy)
        civil_due_q.push_back(civil_from_ms(in_ms_since_epoch));
      if (out_valid) begin
        if (civil_due_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: %0d-%0d-%0d status %0d",
                                    out_year, out_month, out_day, out_status));
        end else begin
          want = civil_due_q.pop_front();
          check_field("year", want.cal.year, out_year, want.stamp);
          check_field("month", want.cal.month, out_month, want.stamp);
          check_field("day", want.cal.day, out_day, want.stamp);
          check_field("status", want.cal.status, out_status, want.stamp);
          check_field("hour", want.tod.hour, out_hour, want.stamp);
          check_field("minute", want.tod.minute, out_minute, want.stamp);
          check_field("second", want.tod.second, out_second, want.stamp);
          check_field("millisecond", want.tod.msec, out_millisecond, want.stamp);
        end
      end
    end
    fail_count <= fails;
    due_count  <= civil_due_q.size();
  end

endmodule

// ----- tb/epoch_ms_to_civil_datetime_tb.sv -----
// epoch_ms_to_civil_datetime_tb: drives directed and random timestamps into the
// converter with random gaps and bursts; ecdt_checker predicts and compares results
// depends on ecdt_pkg, ecdt_checker and the epoch_ms_to_civil_datetime rtl
module epoch_ms_to_civil_datetime_tb;

  localparam longint MS_DAY      = 86400000;
  localparam longint DAY_SPAN    = 3257812;   // whole days reachable either side
  localparam int     RANDOM_ITEMS = 650;
  localparam int     WATCH_LIMIT  = 2000;
  localparam int     TAIL_CYCLES  = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [48:0] in_ms_since_epoch = '0;
  logic        out_valid;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [9:0]  out_millisecond;
  logic        out_status;
  int          fail_count;
  int          due_count;
  int          idle_run = 0;

  epoch_ms_to_civil_datetime uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_ms_since_epoch(in_ms_since_epoch),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_millisecond (out_millisecond),
    .out_status      (out_status)
  );

  ecdt_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_ms_since_epoch(in_ms_since_epoch),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_millisecond (out_millisecond),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .due_count       (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // day count since the epoch of a civil date, for aiming at calendar edges
  function automatic longint epoch_day(longint y, longint m, longint d);
    longint era, yoe, doy, yy;
    yy  = (m <= 2) ? y - 1 : y;
    era = (yy >= 0 ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
  endfunction

  // present one item after a gap, hold it until accepted
  task automatic send_stamp(longint stamp, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_ms_since_epoch <= stamp[48:0];
    do @(posedge clk); while (busy);
  endtask

  // watchdog on cycles where nothing moves on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_run <= 0;
      end else if (idle_run >= WATCH_LIMIT) begin
        $display("epoch_ms_to_civil_datetime_tb: errors");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin : stimulus
    longint edges[$];
    longint stamp, d;
    int     gap, pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // epoch, field extremes, range limits, leap and century edges
    edges = '{0, -1, 1, 86399999, 86400000, -86400000, -86400001,
              64'sh0000_FFFF_FFFF_FFFF, -64'sh0001_0000_0000_0000,
              epoch_day(0, 1, 1) * MS_DAY, epoch_day(0, 1, 1) * MS_DAY - 1,
              epoch_day(10000, 1, 1) * MS_DAY - 1, epoch_day(10000, 1, 1) * MS_DAY,
              epoch_day(2000, 2, 29) * MS_DAY + 43200000,
              epoch_day(2000, 3, 1) * MS_DAY - 1, epoch_day(2000, 3, 1) * MS_DAY,
              epoch_day(2100, 3, 1) * MS_DAY - 1, epoch_day(2100, 3, 1) * MS_DAY,
              epoch_day(2000, 1, 1) * MS_DAY - 1, epoch_day(1600, 2, 29) * MS_DAY,
              epoch_day(9999, 12, 31) * MS_DAY + 43199999};
    foreach (edges[i])
      send_stamp(edges[i], $urandom_range(0, 9));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        // any 49-bit pattern
        stamp = {$urandom, $urandom};
        stamp = {{15{stamp[48]}}, stamp[48:0]};
      end else if (pick <= 6) begin
        // anywhere in years 0 to 9999
        d     = longint'($urandom_range(0, 3652424)) - 719528;
        stamp = d * MS_DAY + longint'($urandom_range(0, 86399999));
      end else if (pick <= 8) begin
        // just around midnight, whole range
        d     = longint'($urandom_range(0, 2 * DAY_SPAN)) - DAY_SPAN;
        stamp = d * MS_DAY + longint'($urandom_range(0, 3)) - 2;
      end else begin
        // month starts, years straddling the valid range
        d     = epoch_day(longint'($urandom_range(0, 10002)) - 1,
                          longint'($urandom_range(1, 12)), 1);
        stamp = d * MS_DAY + longint'($urandom_range(0, 2)) - 1;
      end
      // every third stretch of 40 items runs back to back
      gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
      send_stamp(stamp, gap);
    end
    start <= 1'b0;

    // drain, then give any stray result time to show
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("epoch_ms_to_civil_datetime_tb: clean");
    else
      $display("epoch_ms_to_civil_datetime_tb: errors");
    $finish;
  end

endmodule
